### rtl/core/twsf_pkg.sv
// ----------------------------------------------------------------------------
// twsf_pkg: shared constants of the trimmed weighted speed filter
// Unsigned Q16 coefficients for the window weights and the smoothing blend.
// ----------------------------------------------------------------------------
package twsf_pkg;

  // Window weights, newest to oldest kept sample (Q16)
  localparam logic [15:0] W_NEW    = 16'd32768;  // 0.50
  localparam logic [15:0] W_MID    = 16'd22282;  // 0.34
  localparam logic [15:0] W_OLD    = 16'd10486;  // 0.16

  // Blend coefficients (Q16)
  localparam logic [15:0] K_NEW    = 16'd39322;  // 0.60
  localparam logic [15:0] K_PREV   = 16'd26214;  // 0.40

  localparam int unsigned FRAC_BITS = 16;
  localparam logic [15:0] HALF_Q16  = 16'd32768;

  localparam int unsigned WIN_LEN  = 5;
  localparam int unsigned KEEP_LEN = 3;

endpackage

### rtl/core/twsf_trim.sv
// ----------------------------------------------------------------------------
// twsf_trim: drop one maximum and one minimum from a five-sample window
// Scans from the oldest sample; the three kept samples come out newest first.
// ----------------------------------------------------------------------------
module twsf_trim #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic [twsf_pkg::WIN_LEN-1:0][SAMPLE_WIDTH-1:0]  win_i,
  output logic [twsf_pkg::KEEP_LEN-1:0][SAMPLE_WIDTH-1:0] kept_o
);

  localparam int unsigned WinLen  = twsf_pkg::WIN_LEN;
  localparam int unsigned KeepLen = twsf_pkg::KEEP_LEN;

  logic [SAMPLE_WIDTH-1:0] hi;
  logic [SAMPLE_WIDTH-1:0] lo;
  logic [WinLen-1:0]       hi_drop;
  logic [WinLen-1:0]       lo_drop;

  always_comb begin
    hi = win_i[0];
    lo = win_i[0];
    for (int i = 1; i < WinLen; i++) begin
      if (win_i[i] > hi) hi = win_i[i];
      if (win_i[i] < lo) lo = win_i[i];
    end
  end

  // Oldest matching max goes first; the min is taken from what is left
  always_comb begin
    logic hi_found;
    logic lo_found;
    hi_found = 1'b0;
    lo_found = 1'b0;
    hi_drop  = '0;
    lo_drop  = '0;
    for (int i = WinLen - 1; i >= 0; i--) begin
      if (!hi_found && win_i[i] == hi) begin
        hi_drop[i] = 1'b1;
        hi_found   = 1'b1;
      end else if (!lo_found && win_i[i] == lo) begin
        lo_drop[i] = 1'b1;
        lo_found   = 1'b1;
      end
    end
  end

  // Pack the survivors, newest first
  always_comb begin
    logic [1:0] slot;
    slot   = '0;
    kept_o = '0;
    for (int i = 0; i < WinLen; i++) begin
      if (!hi_drop[i] && !lo_drop[i] && slot < 2'(KeepLen)) begin
        kept_o[slot] = win_i[i];
        slot         = slot + 2'd1;
      end
    end
  end

endmodule

### rtl/core/trimmed_weighted_speed_filter.sv
// ----------------------------------------------------------------------------
// trimmed_weighted_speed_filter: trimmed mean and exponential speed smoothing
// Five-stage pipeline from an encoder pulse count to a smoothed speed.
// ----------------------------------------------------------------------------
// Takes one pulse count word per cycle while pulse_stall_o is low and returns one
// speed word per input, in order. An accepted word passes through the window,
// trim, sum and blend registers to the filter register and is offered from there.
// Stages: window capture (history shifts on acceptance), max/min trim, Q16
// weighted sum, 0.60 blend product, and the final stage that closes the
// smoothing loop with one 0.40 multiply, add and saturate around the filter
// register. Filter value and history clear to zero on reset. Bubbles collapse,
// so input is stalled only when every stage is full and the output is stalled.
module trimmed_weighted_speed_filter #(
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        pulse_valid_i,
  output logic        pulse_stall_o,
  input  logic [15:0] pulse_count_i,
  output logic        filtered_valid_o,
  input  logic        filtered_stall_i,
  output logic [15:0] filtered_speed_o
);

  localparam int unsigned SW       = SAMPLE_WIDTH;
  localparam int unsigned VW       = SAMPLE_WIDTH + twsf_pkg::FRAC_BITS;
  localparam int unsigned PW       = VW + twsf_pkg::FRAC_BITS;
  localparam int unsigned Stages   = 5;
  localparam int unsigned WinLen   = twsf_pkg::WIN_LEN;
  localparam int unsigned KeepLen  = twsf_pkg::KEEP_LEN;
  localparam int unsigned HistLen  = WinLen - 1;

  logic [Stages-1:0] vld_q;
  logic [Stages-1:0] take;
  logic              accept;

  logic [HistLen-1:0][SW-1:0] hist_q;
  logic [WinLen-1:0][SW-1:0]  win_q;
  logic [KeepLen-1:0][SW-1:0] kept_d;
  logic [KeepLen-1:0][SW-1:0] kept_q;
  logic [VW-1:0]              wsum_d;
  logic [VW-1:0]              wsum_q;
  logic [VW-1:0]              blend_d;
  logic [VW-1:0]              blend_q;
  logic [VW-1:0]              smooth_d;
  logic [VW-1:0]              smooth_q;
  logic [SW-1:0]              sample;
  logic [PW-1:0]              prod_new;
  logic [PW-1:0]              prod_prev;
  logic [VW:0]                sum_full;
  logic [SW-1:0]              int_part;

  // A stage takes a word when it is empty or its word moves on
  always_comb begin
    take[Stages-1] = !vld_q[Stages-1] || !filtered_stall_i;
    for (int k = Stages - 2; k >= 0; k--) begin
      take[k] = !vld_q[k] || take[k+1];
    end
  end

  assign accept        = pulse_valid_i && take[0];
  assign pulse_stall_o = !take[0];
  assign sample        = SW'(pulse_count_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (take[0]) vld_q[0] <= pulse_valid_i;
      for (int k = 1; k < Stages; k++) begin
        if (take[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // Stage 1: capture window, advance history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
    end else if (accept) begin
      hist_q <= {hist_q[HistLen-2:0], sample};
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) win_q <= {hist_q, sample};
  end

  // Stage 2: trim
  twsf_trim #(
    .SAMPLE_WIDTH (SW)
  ) u_trim (
    .win_i  (win_q),
    .kept_o (kept_d)
  );

  always_ff @(posedge clk_i) begin
    if (take[1] && vld_q[0]) kept_q <= kept_d;
  end

  // Stage 3: weighted sum, exact in Q16
  assign wsum_d = (VW)'(twsf_pkg::W_NEW) * (VW)'(kept_q[0])
                + (VW)'(twsf_pkg::W_MID) * (VW)'(kept_q[1])
                + (VW)'(twsf_pkg::W_OLD) * (VW)'(kept_q[2]);

  always_ff @(posedge clk_i) begin
    if (take[2] && vld_q[1]) wsum_q <= wsum_d;
  end

  // Stage 4: new-sample share of the blend, rounded to Q16
  assign prod_new = (PW)'(twsf_pkg::K_NEW) * (PW)'(wsum_q) + (PW)'(twsf_pkg::HALF_Q16);
  assign blend_d  = prod_new[PW-1:twsf_pkg::FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (take[3] && vld_q[2]) blend_q <= blend_d;
  end

  // Stage 5: close the smoothing loop; saturate on rounding overshoot
  assign prod_prev = (PW)'(twsf_pkg::K_PREV) * (PW)'(smooth_q)
                   + (PW)'(twsf_pkg::HALF_Q16);
  assign sum_full  = {1'b0, blend_q} + {1'b0, prod_prev[PW-1:twsf_pkg::FRAC_BITS]};
  assign smooth_d  = sum_full[VW] ? {VW{1'b1}} : sum_full[VW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q <= '0;
    end else if (take[4] && vld_q[3]) begin
      smooth_q <= smooth_d;
    end
  end

  assign int_part         = smooth_q[VW-1:twsf_pkg::FRAC_BITS];
  assign filtered_speed_o = 16'(int_part);
  assign filtered_valid_o = vld_q[Stages-1];

endmodule

### rtl/core/twsf_checker.sv
// ----------------------------------------------------------------------------
// twsf_checker: port-level checks for the trimmed weighted speed filter
// Tracks words in flight and checks output handshake and backpressure.
// ----------------------------------------------------------------------------
module twsf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        pulse_valid_i,
  input logic        pulse_stall_o,
  input logic        filtered_valid_o,
  input logic        filtered_stall_i,
  input logic [15:0] filtered_speed_o
);

  localparam logic [2:0] Depth = 3'd5;

  logic       in_fire;
  logic       out_fire;
  logic [2:0] flight_q;

  assign in_fire  = pulse_valid_i && !pulse_stall_o;
  assign out_fire = filtered_valid_o && !filtered_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flight_q <= '0;
    end else begin
      flight_q <= flight_q + {2'b0, in_fire} - {2'b0, out_fire};
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filtered_valid_o && filtered_stall_i |=> filtered_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    filtered_valid_o && filtered_stall_i |=> $stable(filtered_speed_o))
    else $error("output word changed while stalled");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flight_q == 3'd0 |-> !filtered_valid_o)
    else $error("output word with no input in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flight_q <= Depth)
    else $error("more words in flight than pipeline stages");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pulse_stall_o |-> filtered_valid_o && filtered_stall_i && flight_q == Depth)
    else $error("input stalled while pipeline can advance");

endmodule

bind trimmed_weighted_speed_filter twsf_checker u_twsf_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .pulse_valid_i    (pulse_valid_i),
  .pulse_stall_o    (pulse_stall_o),
  .filtered_valid_o (filtered_valid_o),
  .filtered_stall_i (filtered_stall_i),
  .filtered_speed_o (filtered_speed_o)
);
